/* rtl/core/pncm_pkg.sv */
// shared types and constants for the palette nearest color match unit
package pncm_pkg;

	// default palette depth and the fixed field widths
	localparam int unsigned PaletteEntriesDef = 256;
	localparam int unsigned ChanW            = 8;
	localparam int unsigned EntryIdxW        = 8;
	localparam int unsigned DistW            = 10;
	localparam int unsigned BestDistW        = 15;
	localparam logic [BestDistW-1:0] StartDist = 15'h7fff;

	// request kind carried on tuser
	typedef enum logic {
		OP_LOAD  = 1'b0,
		OP_MATCH = 1'b1
	} op_t;

	typedef struct packed {
		logic [ChanW-1:0] blue;
		logic [ChanW-1:0] green;
		logic [ChanW-1:0] red;
	} color_t;

	// controller to datapath
	typedef struct packed {
		logic wr_en;
		logic start;
		logic issue;
		logic publish;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic last_addr;
		logic pipe_empty;
		logic out_busy;
	} status_t;

endpackage

/* rtl/core/palette_nearest_color_match_unit.sv */
// top level of the palette nearest color match unit
// A load request (tuser op = 0) writes one palette entry and returns
// nothing; loads to an index at or beyond PALETTE_ENTRIES are dropped. A match request
// (tuser op = 1) scans the whole palette through its single read port, one entry per
// cycle, and returns the index with the smallest sum of absolute channel differences,
// the highest index winning ties. A match occupies the unit from acceptance until the
// next request can be taken. The result sits in an output register, so the next
// request is accepted while a result still waits; a later match whose scan ends while
// that result is still not taken holds the request side closed until it is. Every
// palette entry must be loaded before the first match; entries hold no value after reset.
module palette_nearest_color_match_unit #(
	parameter int unsigned PALETTE_ENTRIES = pncm_pkg::PaletteEntriesDef
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // entry_index, red, green, blue
	input  logic [0:0]  s_tuser,   // op
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata    // best_index
);
	import pncm_pkg::*;

	cmd_t    cmd;
	status_t status;
	color_t  in_color;
	op_t     in_op;

	// unpack the request
	assign in_op          = op_t'(s_tuser[0]);
	assign in_color.red   = s_tdata[15:8];
	assign in_color.green = s_tdata[23:16];
	assign in_color.blue  = s_tdata[31:24];

	pncm_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_valid (s_tvalid),
		.s_op    (in_op),
		.ready   (s_tready),
		.cmd     (cmd),
		.status  (status)
	);

	pncm_datapath #(
		.PALETTE_ENTRIES (PALETTE_ENTRIES)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.status    (status),
		.in_index  (s_tdata[7:0]),
		.in_color  (in_color),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_index (m_tdata)
	);

	// an accepted match closes the request side until its result is out
	a_match_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready && (in_op == OP_MATCH)) |=> !s_tready)
		else $error("request side open during a scan");

	// a result is only published once the distance pipeline has drained
	a_publish_drained: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.publish |-> (status.pipe_empty && !status.out_busy))
		else $error("result published with scan still in flight");

	// no palette read is issued while new requests are taken
	a_no_issue_when_ready: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> !cmd.issue)
		else $error("scan running while request side is open");

endmodule

/* rtl/core/pncm_datapath.sv */
// palette memory, distance pipeline, best-match tracking and result register
module pncm_datapath #(
	parameter int unsigned PALETTE_ENTRIES = pncm_pkg::PaletteEntriesDef
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  pncm_pkg::cmd_t                      cmd,
	output pncm_pkg::status_t                   status,
	input  logic [pncm_pkg::EntryIdxW-1:0]      in_index,
	input  pncm_pkg::color_t                    in_color,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [pncm_pkg::EntryIdxW-1:0]      out_index
);
	import pncm_pkg::*;

	localparam int unsigned IdxW = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;
	localparam logic [IdxW-1:0] LastIdx = IdxW'(PALETTE_ENTRIES - 1);

	color_t              pal_mem_q [PALETTE_ENTRIES];
	color_t              pixel_q;
	logic [IdxW-1:0]     addr_q;
	color_t              rd_s1;
	logic [IdxW-1:0]     idx_s1;
	logic                vld_s1;
	logic [DistW-1:0]    dist_s2;
	logic [IdxW-1:0]     idx_s2;
	logic                vld_s2;
	logic [BestDistW-1:0] best_dist_q;
	logic [IdxW-1:0]     best_idx_q;
	logic                out_valid_q;
	logic [EntryIdxW-1:0] out_index_q;
	logic                in_range;
	logic [DistW-1:0]    dist_sum;

	function automatic logic [ChanW-1:0] abs_diff(logic [ChanW-1:0] a, logic [ChanW-1:0] b);
		return (a >= b) ? (a - b) : (b - a);
	endfunction

	// loads past the palette depth are dropped
	assign in_range = ({1'b0, in_index} < (EntryIdxW + 1)'(PALETTE_ENTRIES));

	// palette write port
	always_ff @(posedge clk) begin
		if (cmd.wr_en && in_range) begin
			pal_mem_q[IdxW'(in_index)] <= in_color;
		end
	end

	// read address counter and registered read
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			pixel_q <= in_color;
			addr_q  <= '0;
		end else if (cmd.issue) begin
			addr_q <= addr_q + 1'b1;
		end
		rd_s1  <= pal_mem_q[addr_q];
		idx_s1 <= addr_q;
	end

	// l1 distance of the entry read last cycle
	assign dist_sum = DistW'(abs_diff(rd_s1.red, pixel_q.red))
		+ DistW'(abs_diff(rd_s1.green, pixel_q.green))
		+ DistW'(abs_diff(rd_s1.blue, pixel_q.blue));

	always_ff @(posedge clk) begin
		dist_s2 <= dist_sum;
		idx_s2  <= idx_s1;
	end

	// pipeline valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			vld_s1 <= cmd.issue;
			vld_s2 <= vld_s1;
		end
	end

	// running best, ties go to the later index
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			best_dist_q <= StartDist;
			best_idx_q  <= '0;
		end else if (vld_s2 && (BestDistW'(dist_s2) <= best_dist_q)) begin
			best_dist_q <= BestDistW'(dist_s2);
			best_idx_q  <= idx_s2;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.publish) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.publish) begin
			out_index_q <= EntryIdxW'(best_idx_q);
		end
	end

	assign out_valid = out_valid_q;
	assign out_index = out_index_q;

	assign status.last_addr  = (addr_q == LastIdx);
	assign status.pipe_empty = !vld_s1 && !vld_s2;
	assign status.out_busy   = out_valid_q && !out_ready;

endmodule

/* rtl/core/pncm_ctrl.sv */
// controller state machine sequencing loads and palette scans
module pncm_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_valid,
	input  pncm_pkg::op_t      s_op,
	output logic               ready,
	output pncm_pkg::cmd_t     cmd,
	input  pncm_pkg::status_t  status
);
	import pncm_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN
	} state_t;

	state_t state_q;
	logic   ready_q;
	logic   accept;

	assign accept = s_valid && ready_q;

	// state and ready register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ready_q <= 1'b1;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept && (s_op == OP_MATCH)) begin
						state_q <= ST_SCAN;
						ready_q <= 1'b0;
					end
				end
				ST_SCAN: begin
					if (status.last_addr) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (status.pipe_empty && !status.out_busy) begin
						state_q <= ST_IDLE;
						ready_q <= 1'b1;
					end
				end
				default: begin
					state_q <= ST_IDLE;
					ready_q <= 1'b1;
				end
			endcase
		end
	end

	// command decode
	always_comb begin
		cmd.wr_en   = accept && (s_op == OP_LOAD);
		cmd.start   = accept && (s_op == OP_MATCH);
		cmd.issue   = (state_q == ST_SCAN);
		cmd.publish = (state_q == ST_DRAIN) && status.pipe_empty && !status.out_busy;
	end

	assign ready = ready_q;

endmodule
